// ===== rtl/dq_pkg.sv =====
// shared types and constants of the double-ended queue
package dq_pkg;

    localparam int WORD_W = 32;
    localparam logic signed [WORD_W-1:0] NONE_WORD = -32'sd1;

    typedef enum logic [2:0] {
        MODE_QUERY      = 3'd0,
        MODE_PUSH_FRONT = 3'd1,
        MODE_PUSH_BACK  = 3'd2,
        MODE_POP_FRONT  = 3'd3,
        MODE_POP_BACK   = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic rd_front;
        logic rd_back;
        logic load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic empty;
    } t_dp_stat;

endpackage

// ===== rtl/dq_in_if.sv =====
// request channel of the double-ended queue
interface dq_in_if;
    logic                              valid;
    logic                              ready;
    logic [2:0]                        mode;
    logic signed [dq_pkg::WORD_W-1:0]  value;

    modport source (output valid, output mode, output value, input ready);
    modport sink (input valid, input mode, input value, output ready);
endinterface

// ===== rtl/dq_out_if.sv =====
// result channel of the double-ended queue
interface dq_out_if #(
    parameter int CNT_W = 11
);
    logic                              valid;
    logic                              ready;
    logic signed [dq_pkg::WORD_W-1:0]  popped;
    logic [1:0]                        status;
    logic [CNT_W-1:0]                  count;
    logic                              is_empty;
    logic signed [dq_pkg::WORD_W-1:0]  front_word;
    logic signed [dq_pkg::WORD_W-1:0]  back_word;

    modport source (output valid, output popped, output status, output count,
                    output is_empty, output front_word, output back_word, input ready);
    modport sink (input valid, input popped, input status, input count,
                  input is_empty, input front_word, input back_word, output ready);
endinterface

// ===== rtl/dq_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ===== rtl/dq_datapath.sv =====
// pointers, occupancy, entry store and result registers of the queue
module dq_datapath #(
    parameter int DEPTH = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dq_pkg::t_dp_cmd                   i_cmd,
    output dq_pkg::t_dp_stat                  o_stat,
    input  logic [2:0]                        i_mode,
    input  logic signed [dq_pkg::WORD_W-1:0]  i_value,
    output logic signed [dq_pkg::WORD_W-1:0]  o_popped,
    output logic [1:0]                        o_status,
    output logic [$clog2(DEPTH+1)-1:0]        o_count,
    output logic                              o_is_empty,
    output logic signed [dq_pkg::WORD_W-1:0]  o_front_word,
    output logic signed [dq_pkg::WORD_W-1:0]  o_back_word
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] i);
        return (i == LAST_IDX) ? '0 : i + AW'(1);
    endfunction

    function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] i);
        return (i == '0) ? LAST_IDX : i - AW'(1);
    endfunction

    logic [AW-1:0]                     r_head;
    logic [AW-1:0]                     r_tail;
    logic [CW-1:0]                     r_occ;
    dq_pkg::t_mode                     r_mode;
    logic signed [dq_pkg::WORD_W-1:0]  r_value;
    logic signed [dq_pkg::WORD_W-1:0]  r_popped;
    dq_pkg::t_status                   r_status;
    logic signed [dq_pkg::WORD_W-1:0]  r_front_tmp;
    logic signed [dq_pkg::WORD_W-1:0]  r_out_popped;
    dq_pkg::t_status                   r_out_status;
    logic [CW-1:0]                     r_out_count;
    logic                              r_out_empty;
    logic signed [dq_pkg::WORD_W-1:0]  r_out_front;
    logic signed [dq_pkg::WORD_W-1:0]  r_out_back;

    logic                              w_full;
    logic                              w_empty;
    logic                              w_wr_en;
    logic [AW-1:0]                     w_wr_addr;
    logic [AW-1:0]                     w_rd_addr;
    logic [dq_pkg::WORD_W-1:0]         w_rd_data;

    assign w_full  = (r_occ == FULL_CNT);
    assign w_empty = (r_occ == '0);

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_tail;
        if (i_cmd.exec && !w_full) begin
            case (r_mode)
                dq_pkg::MODE_PUSH_FRONT: begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = idx_dec(r_head);
                end
                dq_pkg::MODE_PUSH_BACK: begin
                    w_wr_en   = 1'b1;
                end
                default: begin
                    w_wr_en   = 1'b0;
                end
            endcase
        end
    end

    assign w_rd_addr = i_cmd.rd_back ? idx_dec(r_tail) : r_head;

    dq_ram #(
        .WIDTH (dq_pkg::WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (r_value),
        .i_rd_en   (i_cmd.rd_front | i_cmd.rd_back),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_occ  <= '0;
        end else if (i_cmd.exec) begin
            case (r_mode)
                dq_pkg::MODE_PUSH_FRONT: begin
                    if (!w_full) begin
                        r_head <= idx_dec(r_head);
                        r_occ  <= r_occ + CW'(1);
                    end
                end
                dq_pkg::MODE_PUSH_BACK: begin
                    if (!w_full) begin
                        r_tail <= idx_inc(r_tail);
                        r_occ  <= r_occ + CW'(1);
                    end
                end
                dq_pkg::MODE_POP_FRONT: begin
                    if (!w_empty) begin
                        r_head <= idx_inc(r_head);
                        r_occ  <= r_occ - CW'(1);
                    end
                end
                dq_pkg::MODE_POP_BACK: begin
                    if (!w_empty) begin
                        r_tail <= idx_dec(r_tail);
                        r_occ  <= r_occ - CW'(1);
                    end
                end
                default: begin
                    r_occ <= r_occ;
                end
            endcase
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode  <= dq_pkg::t_mode'(i_mode);
            r_value <= i_value;
        end
        if (i_cmd.exec) begin
            r_popped <= dq_pkg::NONE_WORD;
            r_status <= dq_pkg::ST_DONE;
            case (r_mode)
                dq_pkg::MODE_PUSH_FRONT, dq_pkg::MODE_PUSH_BACK: begin
                    if (w_full) begin
                        r_status <= dq_pkg::ST_FULL;
                    end
                end
                // the previous result still holds the end words
                dq_pkg::MODE_POP_FRONT: begin
                    if (w_empty) begin
                        r_status <= dq_pkg::ST_EMPTY;
                    end else begin
                        r_popped <= r_out_front;
                    end
                end
                dq_pkg::MODE_POP_BACK: begin
                    if (w_empty) begin
                        r_status <= dq_pkg::ST_EMPTY;
                    end else begin
                        r_popped <= r_out_back;
                    end
                end
                default: begin
                    r_status <= dq_pkg::ST_DONE;
                end
            endcase
        end
        if (i_cmd.rd_back) begin
            r_front_tmp <= w_rd_data;
        end
        if (i_cmd.load) begin
            r_out_popped <= r_popped;
            r_out_status <= r_status;
            r_out_count  <= r_occ;
            r_out_empty  <= w_empty;
            r_out_front  <= w_empty ? dq_pkg::NONE_WORD : r_front_tmp;
            r_out_back   <= w_empty ? dq_pkg::NONE_WORD : w_rd_data;
        end
    end

    assign o_stat.empty = w_empty;
    assign o_popped     = r_out_popped;
    assign o_status     = r_out_status;
    assign o_count      = r_out_count;
    assign o_is_empty   = r_out_empty;
    assign o_front_word = r_out_front;
    assign o_back_word  = r_out_back;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= FULL_CNT)
        else $error("occupancy beyond depth");

    a_ends_meet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_occ == '0 || r_occ == FULL_CNT) |-> r_head == r_tail)
        else $error("pointers apart on empty or full queue");

    a_ends_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head == r_tail) |-> (r_occ == '0 || r_occ == FULL_CNT))
        else $error("pointers equal on partly filled queue");
endmodule

// ===== rtl/dq_ctrl.sv =====
// sequencer of one queue operation and the result handshake
module dq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output dq_pkg::t_dp_cmd  o_cmd,
    input  dq_pkg::t_dp_stat i_stat
);
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RD_FRONT,
        S_RD_BACK,
        S_LOAD
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   w_load;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    // result register is free or being emptied this cycle
    assign w_load      = (r_state == S_LOAD) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_RD_FRONT;
            end
            S_RD_FRONT: begin
                // no end words to fetch once the queue is empty
                n_state = i_stat.empty ? S_LOAD : S_RD_BACK;
            end
            S_RD_BACK: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd.capture  = i_in_valid && o_in_ready;
        o_cmd.exec     = (r_state == S_EXEC);
        o_cmd.rd_front = (r_state == S_RD_FRONT);
        o_cmd.rd_back  = (r_state == S_RD_BACK);
        o_cmd.load     = w_load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_state == S_EXEC)
        else $error("accepted request not executed");

    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_load))
        else $error("result raised without a load");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_state == S_IDLE && r_out_valid))
        else $error("load did not finish the operation");
endmodule

// ===== rtl/double_ended_queue_unit.sv =====
// Bounded double-ended queue of signed 32-bit words held as a ring buffer in a
// single RAM of DEPTH entries. Each request takes one operation (query, push
// front, push back, pop front, pop back) and gives one result with the popped
// word, a status, the entry count and the words now at both ends. One request
// is handled at a time: the next request is accepted only after the result of
// the last one is loaded, and the load waits until the result register is free.
// The sequence is set by the RAM's single read port, which fetches the front word
// and then, when the queue ends non-empty, the back word after the pointers move;
// popped words come from the previous result's end words. The result channel's
// count field is $clog2(DEPTH+1) bits wide. No clearing pass follows reset.
module double_ended_queue_unit #(
    parameter int DEPTH = 1024
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    dq_in_if.sink    i_in,
    dq_out_if.source o_out
);
    dq_pkg::t_dp_cmd  w_cmd;
    dq_pkg::t_dp_stat w_stat;
    logic             w_in_ready;
    logic             w_out_valid;

    dq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    dq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_mode       (i_in.mode),
        .i_value      (i_in.value),
        .o_popped     (o_out.popped),
        .o_status     (o_out.status),
        .o_count      (o_out.count),
        .o_is_empty   (o_out.is_empty),
        .o_front_word (o_out.front_word),
        .o_back_word  (o_out.back_word)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;
endmodule

// ===== sim/dq_checker.sv =====
// checker for the double-ended queue: predicts the result of every request and compares
module dq_checker #(
    parameter int DEPTH = 1024,
    parameter int CNT_W = 11
) (
    input  logic i_clk,
    input  logic i_rst_n,
    dq_in_if     i_req,
    dq_out_if    i_res,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct {
        logic [dq_pkg::WORD_W-1:0] popped;
        logic [1:0]                status;
        logic [CNT_W-1:0]          count;
        logic                      is_empty;
        logic [dq_pkg::WORD_W-1:0] front_word;
        logic [dq_pkg::WORD_W-1:0] back_word;
    } t_dq_result;

    // shadow copy of the ring
    logic [dq_pkg::WORD_W-1:0] ring_words [DEPTH];
    int unsigned               head_idx = 0;
    int unsigned               tail_idx = 0;
    int unsigned               fill     = 0;

    t_dq_result expected_results [$];
    int         mismatch_total = 0;

    assign o_fail_count = mismatch_total;

    function automatic int unsigned idx_before(int unsigned idx);
        return (idx == 0) ? DEPTH - 1 : idx - 1;
    endfunction

    function automatic int unsigned idx_after(int unsigned idx);
        return (idx + 1 >= DEPTH) ? 0 : idx + 1;
    endfunction

    task automatic step_queue(input logic [2:0] mode, input logic [dq_pkg::WORD_W-1:0] word,
                              output t_dq_result res);
        res.popped     = dq_pkg::NONE_WORD;
        res.status     = dq_pkg::ST_DONE;
        res.front_word = dq_pkg::NONE_WORD;
        res.back_word  = dq_pkg::NONE_WORD;
        case (mode)
            dq_pkg::MODE_PUSH_FRONT: begin
                if (fill >= DEPTH) begin
                    res.status = dq_pkg::ST_FULL;
                end else begin
                    head_idx = idx_before(head_idx);
                    ring_words[head_idx] = word;
                    fill++;
                end
            end
            dq_pkg::MODE_PUSH_BACK: begin
                if (fill >= DEPTH) begin
                    res.status = dq_pkg::ST_FULL;
                end else begin
                    ring_words[tail_idx] = word;
                    tail_idx = idx_after(tail_idx);
                    fill++;
                end
            end
            dq_pkg::MODE_POP_FRONT: begin
                if (fill == 0) begin
                    res.status = dq_pkg::ST_EMPTY;
                end else begin
                    res.popped = ring_words[head_idx];
                    head_idx = idx_after(head_idx);
                    fill--;
                end
            end
            dq_pkg::MODE_POP_BACK: begin
                if (fill == 0) begin
                    res.status = dq_pkg::ST_EMPTY;
                end else begin
                    tail_idx = idx_before(tail_idx);
                    res.popped = ring_words[tail_idx];
                    fill--;
                end
            end
            // query and the spare codes leave the queue alone
            default: begin
            end
        endcase
        if (fill != 0) begin
            res.front_word = ring_words[head_idx];
            res.back_word  = ring_words[idx_before(tail_idx)];
        end
        res.count    = CNT_W'(fill);
        res.is_empty = (fill == 0);
    endtask

    function automatic void compare_field(string field, logic [dq_pkg::WORD_W-1:0] want,
                                          logic [dq_pkg::WORD_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            mismatch_total++;
        end
    endfunction

    always @(posedge i_clk) begin : track
        t_dq_result want;
        if (!i_rst_n) begin
            head_idx = 0;
            tail_idx = 0;
            fill     = 0;
            expected_results.delete();
        end else begin
            // result first, so a request taken on the same edge cannot claim it
            if (i_res.valid === 1'b1 && i_res.ready === 1'b1) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result with no request waiting, expected none, actual %h",
                             $time, i_res.popped);
                    mismatch_total++;
                end else begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    compare_field("popped", want.popped, i_res.popped);
                    compare_field("status", dq_pkg::WORD_W'(want.status),
                                  dq_pkg::WORD_W'(i_res.status));
                    compare_field("count", dq_pkg::WORD_W'(want.count),
                                  dq_pkg::WORD_W'(i_res.count));
                    compare_field("is_empty", dq_pkg::WORD_W'(want.is_empty),
                                  dq_pkg::WORD_W'(i_res.is_empty));
                    compare_field("front_word", want.front_word, i_res.front_word);
                    compare_field("back_word", want.back_word, i_res.back_word);
                end
            end
            if (i_req.valid === 1'b1 && i_req.ready === 1'b1) begin
                step_queue(i_req.mode, i_req.value, want);
                expected_results.insert(expected_results.size(), want);
            end
        end
        o_pending <= expected_results.size();
    end

endmodule

// ===== sim/tb_top.sv =====
// top of the double-ended queue testbench: clock, reset, request stimulus and verdict
module tb_top;

    localparam int DEPTH        = 1024;
    localparam int CNT_W        = $clog2(DEPTH + 1);
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;

    localparam logic [2:0] MODE_SPARE_LO = 3'd5;
    localparam logic [2:0] MODE_SPARE_MID = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    localparam logic [dq_pkg::WORD_W-1:0] WORD_MAX = 32'h7fff_ffff;
    localparam logic [dq_pkg::WORD_W-1:0] WORD_MIN = 32'h8000_0000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    int   burst_left = 0;
    bit   sender_steady = 1'b0;

    dq_in_if in_ch ();
    dq_out_if #(.CNT_W(CNT_W)) out_ch ();

    double_ended_queue_unit #(.DEPTH(DEPTH)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    dq_checker #(.DEPTH(DEPTH), .CNT_W(CNT_W)) result_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (in_ch),
        .i_res        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: the stall style rotates through always ready, random, a periodic pattern and mostly ready
    always @(posedge i_clk) begin
        case ((cycle_count / 700) % 4)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= 1'($urandom_range(0, 1));
            2: out_ch.ready <= ((cycle_count % 3) == 0);
            default: out_ch.ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    function automatic logic [dq_pkg::WORD_W-1:0] rand_word();
        case ($urandom_range(0, 15))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return '0;
            3: return dq_pkg::NONE_WORD;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [2:0] pick_mode(int unsigned push_pct, int unsigned pop_pct);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < push_pct) begin
            return $urandom_range(0, 1) ? dq_pkg::MODE_PUSH_FRONT : dq_pkg::MODE_PUSH_BACK;
        end
        if (roll < push_pct + pop_pct) begin
            return $urandom_range(0, 1) ? dq_pkg::MODE_POP_FRONT : dq_pkg::MODE_POP_BACK;
        end
        if ($urandom_range(0, 1)) begin
            return dq_pkg::MODE_QUERY;
        end
        return 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
    endfunction

    // one request; returns at the edge that takes it
    task automatic send_request(input logic [2:0] mode, input logic [dq_pkg::WORD_W-1:0] word);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = sender_steady ? 0 : ($urandom_range(0, 2) == 0 ? $urandom_range(1, 9) : 0);
            if (gap != 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        in_ch.valid <= 1'b1;
        in_ch.mode  <= mode;
        in_ch.value <= word;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        burst_left--;
    endtask

    task automatic pause_until_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        int n;
        in_ch.valid <= 1'b0;
        in_ch.mode  <= dq_pkg::MODE_QUERY;
        in_ch.value <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty queue, index wrap at the front, extreme words, spare codes
        send_request(dq_pkg::MODE_QUERY, rand_word());
        send_request(dq_pkg::MODE_POP_FRONT, WORD_MAX);
        send_request(dq_pkg::MODE_POP_BACK, WORD_MIN);
        send_request(dq_pkg::MODE_PUSH_FRONT, WORD_MAX);
        send_request(dq_pkg::MODE_PUSH_BACK, WORD_MIN);
        send_request(dq_pkg::MODE_PUSH_FRONT, '0);
        send_request(dq_pkg::MODE_PUSH_BACK, dq_pkg::NONE_WORD);
        send_request(dq_pkg::MODE_QUERY, WORD_MAX);
        send_request(MODE_SPARE_LO, $urandom());
        send_request(MODE_SPARE_MID, $urandom());
        send_request(MODE_SPARE_HI, $urandom());
        send_request(dq_pkg::MODE_POP_BACK, '0);
        send_request(dq_pkg::MODE_POP_FRONT, dq_pkg::NONE_WORD);
        send_request(dq_pkg::MODE_POP_FRONT, '0);
        send_request(dq_pkg::MODE_POP_BACK, '0);
        send_request(dq_pkg::MODE_POP_BACK, '0);
        send_request(dq_pkg::MODE_PUSH_BACK, 32'h5555_5555);
        send_request(dq_pkg::MODE_POP_FRONT, '0);
        send_request(dq_pkg::MODE_PUSH_FRONT, 32'haaaa_aaaa);
        send_request(dq_pkg::MODE_POP_BACK, '0);
        send_request(dq_pkg::MODE_QUERY, '0);

        // balanced walk near empty
        pause_until_drained();
        for (n = 0; n < 300; n++) begin
            send_request(pick_mode(45, 45), rand_word());
        end

        // fill to capacity and keep pushing against it
        pause_until_drained();
        for (n = 0; n < 1150; n++) begin
            sender_steady = (n >= 400 && n < 650);
            send_request(pick_mode(97, 2), rand_word());
        end
        sender_steady = 1'b0;

        // drain mostly by pops
        pause_until_drained();
        for (n = 0; n < 400; n++) begin
            send_request(pick_mode(8, 88), rand_word());
        end

        pause_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
